// File: design/tts_pkg.sv
// Shared types, constants and saturation helpers for the tridiagonal solver.
// Depends on nothing; every other file imports it.
package tts_pkg;

   localparam int MAX_ROWS  = 64;
   localparam int FRAC_BITS = 16;
   localparam int ROW_W     = 6;
   localparam int DVD_W     = 32 + FRAC_BITS;
   localparam int Q_DEPTH   = 4;
   localparam int QP_W      = $clog2(Q_DEPTH);

   typedef struct packed {
      logic signed [31:0] sub_diag;
      logic signed [31:0] main_diag;
      logic signed [31:0] super_diag;
      logic signed [31:0] rhs;
      logic               last_row;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]   row_index;
      logic signed [31:0] solution;
      logic               last_of_run;
      logic               singular;
   } rsp_type;

   // Row as tagged by the front part: its place in the system and whether it ends it.
   typedef struct packed {
      req_type          row;
      logic [ROW_W-1:0] idx;
      logic             fin;
   } qent_type;

   typedef struct packed {
      logic full;
      logic avail;
   } qstat_type;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   function automatic logic signed [31:0] sat_wide(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'(S32_MAX);
      lo = 64'(S32_MIN);
      if (v > hi) return S32_MAX;
      if (v < lo) return S32_MIN;
      return v[31:0];
   endfunction

   // Floor shift of a full product, then saturate.
   function automatic logic signed [31:0] fx_scale(input logic signed [63:0] p);
      return sat_wide(p >>> FRAC_BITS);
   endfunction

endpackage

// File: design/tts_front.sv
// Front part: accept rows, tag each with its index and end-of-system mark.
// Depends on tts_pkg.
module tts_front import tts_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   input  qstat_type q_stat,
   output logic      push,
   output qent_type  push_data
);

   logic [ROW_W-1:0] idx_ff, idx_in;
   logic             fin;

   assign req_ready = !q_stat.full;
   assign push      = req_valid && req_ready;
   assign fin       = req_data.last_row || (idx_ff == ROW_W'(MAX_ROWS - 1));

   assign push_data = '{row: req_data, idx: idx_ff, fin: fin};

   always_comb begin
      idx_in = idx_ff;
      if (push) idx_in = fin ? '0 : idx_ff + ROW_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= '0;
      else       idx_ff <= idx_in;
   end

endmodule

// File: design/tts_queue.sv
// Short row queue between the front and back parts.
// Depends on tts_pkg.
module tts_queue import tts_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  qent_type  push_data,
   input  logic      pop,
   output qent_type  head,
   output qstat_type stat
);

   qent_type          slot_ff [Q_DEPTH];
   logic [QP_W-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [QP_W:0]     cnt_ff, cnt_in;

   assign stat.full  = (cnt_ff == (QP_W+1)'(Q_DEPTH));
   assign stat.avail = (cnt_ff != '0);
   assign head       = slot_ff[rp_ff];

   always_comb begin
      wp_in  = push ? wp_ff + QP_W'(1) : wp_ff;
      rp_in  = pop  ? rp_ff + QP_W'(1) : rp_ff;
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + (QP_W+1)'(1);
      if (!push && pop) cnt_in = cnt_ff - (QP_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= push_data;
   end

endmodule

// File: design/tts_div.sv
// Bit-serial restoring divider: sat32(num * 2^FRAC_BITS / den), zero pivot saturates by numerator sign.
// Depends on tts_pkg.
module tts_div import tts_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [32:0] num,
   input  logic signed [31:0] den,
   output logic               done,
   output logic signed [31:0] quot
);

   localparam int CNT_W = $clog2(DVD_W);

   logic             busy_ff, fin_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DVD_W-1:0] quo_ff;
   logic [31:0]      rem_ff, dmag_ff;
   logic             neg_ff, nneg_ff, nz_ff, dz_ff;
   logic [31:0]      nmag;
   logic [32:0]      trial;
   logic [31:0]      dmag;
   logic             ge;

   // Magnitude of the numerator never exceeds 2^31, so 32 bits hold it.
   assign nmag  = num[32] ? 32'(-num) : 32'(num);
   assign dmag  = den[31] ? 32'(-den) : 32'(den);
   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign ge    = trial >= {1'b0, dmag_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         fin_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DVD_W - 1)) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff  <= {nmag, {FRAC_BITS{1'b0}}};
         rem_ff  <= '0;
         dmag_ff <= dmag;
         neg_ff  <= num[32] ^ den[31];
         nneg_ff <= num[32];
         nz_ff   <= (num != '0);
         dz_ff   <= (den == '0);
      end else if (busy_ff) begin
         rem_ff <= ge ? 32'(trial - {1'b0, dmag_ff}) : trial[31:0];
         quo_ff <= {quo_ff[DVD_W-2:0], ge};
      end
   end

   assign done = fin_ff;

   always_comb begin
      if (dz_ff) begin
         quot = nz_ff ? (nneg_ff ? S32_MIN : S32_MAX) : '0;
      end else if (neg_ff) begin
         if (quo_ff > {{(DVD_W-32){1'b0}}, 32'h8000_0000}) quot = S32_MIN;
         else                                             quot = -$signed(quo_ff[31:0]);
      end else begin
         if (quo_ff > {{(DVD_W-32){1'b0}}, 32'h7FFF_FFFF}) quot = S32_MAX;
         else                                             quot = quo_ff[31:0];
      end
   end

endmodule

// File: design/tts_back.sv
// Back part: forward sweep with coefficient stores, then backward sweep to results.
// Depends on tts_pkg and tts_div.
module tts_back import tts_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  qent_type  head,
   input  logic      q_avail,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   typedef enum logic [10:0] {
      S_IDLE = 11'b000_0000_0001,
      S_RD   = 11'b000_0000_0010,
      S_M1   = 11'b000_0000_0100,
      S_M2   = 11'b000_0000_1000,
      S_M3   = 11'b000_0001_0000,
      S_DST  = 11'b000_0010_0000,
      S_DIV  = 11'b000_0100_0000,
      S_OUT  = 11'b000_1000_0000,
      S_BRD  = 11'b001_0000_0000,
      S_BM   = 11'b010_0000_0000,
      S_BA   = 11'b100_0000_0000
   } state_type;

   state_type          state_ff, state_in;
   qent_type           cur_ff;
   logic signed [31:0] ratio_mem  [MAX_ROWS];
   logic signed [31:0] offset_mem [MAX_ROWS];
   logic signed [31:0] rd_ratio_ff, rd_offset_ff;
   logic [ROW_W-1:0]   rd_addr, row_ff;
   logic signed [63:0] prod_ff;
   logic signed [31:0] den_ff, num_ff, u_ff, u_new;
   logic               zflag_ff, rsp_valid_ff;
   rsp_type            rsp_data_ff;
   logic               div_start, done_r, done_o;
   logic signed [31:0] q_r, q_o;

   assign pop       = (state_ff == S_IDLE) && q_avail;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign div_start = (state_ff == S_DST);
   assign rd_addr   = (state_ff == S_RD) ? cur_ff.idx - ROW_W'(1) : row_ff;
   assign u_new     = sat_wide(64'(fx_scale(prod_ff)) + 64'(rd_offset_ff));

   tts_div u_div_ratio (
      .clock (clock), .reset (reset), .start (div_start),
      .num   (-{cur_ff.row.super_diag[31], cur_ff.row.super_diag}),
      .den   (den_ff), .done (done_r), .quot (q_r)
   );

   tts_div u_div_offset (
      .clock (clock), .reset (reset), .start (div_start),
      .num   ({num_ff[31], num_ff}),
      .den   (den_ff), .done (done_o), .quot (q_o)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (q_avail) state_in = (head.idx == '0) ? S_DST : S_RD;
         S_RD:   state_in = S_M1;
         S_M1:   state_in = S_M2;
         S_M2:   state_in = S_M3;
         S_M3:   state_in = S_DST;
         S_DST:  state_in = S_DIV;
         S_DIV:  if (done_r && done_o) state_in = cur_ff.fin ? S_OUT : S_IDLE;
         S_OUT:  if (rsp_ready) state_in = (row_ff == '0) ? S_IDLE : S_BRD;
         S_BRD:  state_in = S_BM;
         S_BM:   state_in = S_BA;
         S_BA:   state_in = S_OUT;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         zflag_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_DST && den_ff == '0) zflag_ff <= 1'b1;
         if (state_ff == S_DIV && done_r && done_o && cur_ff.fin) rsp_valid_ff <= 1'b1;
         if (state_ff == S_BA) rsp_valid_ff <= 1'b1;
         if (state_ff == S_OUT && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
            if (row_ff == '0) zflag_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_RD || state_ff == S_BRD) begin
         rd_ratio_ff  <= ratio_mem[rd_addr];
         rd_offset_ff <= offset_mem[rd_addr];
      end
      if (state_ff == S_DIV && done_r && done_o) begin
         ratio_mem[cur_ff.idx]  <= q_r;
         offset_mem[cur_ff.idx] <= q_o;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            cur_ff <= head;
            den_ff <= head.row.main_diag;
            num_ff <= head.row.rhs;
         end
         S_M1: prod_ff <= 64'(cur_ff.row.sub_diag * rd_ratio_ff);
         S_M2: begin
            den_ff  <= sat_wide(64'(cur_ff.row.main_diag) + 64'(fx_scale(prod_ff)));
            prod_ff <= 64'(cur_ff.row.sub_diag * rd_offset_ff);
         end
         S_M3: num_ff <= sat_wide(64'(cur_ff.row.rhs) - 64'(fx_scale(prod_ff)));
         S_DIV: begin
            if (done_r && done_o && cur_ff.fin) begin
               row_ff      <= cur_ff.idx;
               u_ff        <= q_o;
               rsp_data_ff <= '{row_index: cur_ff.idx, solution: q_o,
                                last_of_run: (cur_ff.idx == '0), singular: zflag_ff};
            end
         end
         S_OUT: if (rsp_ready) row_ff <= row_ff - ROW_W'(1);
         S_BM:  prod_ff <= 64'(rd_ratio_ff * u_ff);
         S_BA: begin
            u_ff        <= u_new;
            rsp_data_ff <= '{row_index: row_ff, solution: u_new,
                             last_of_run: (row_ff == '0), singular: zflag_ff};
         end
         default: ;
      endcase
   end

endmodule

// File: design/tridiagonal_thomas_solver.sv
// Top level of the Thomas-algorithm tridiagonal solver, Q16.16 fixed point.
// Depends on tts_pkg, tts_front, tts_queue, tts_div and tts_back.
//
//   channel | ports                          | moves
//   --------+--------------------------------+--------------------------------
//   req     | req_valid, req_ready, req_data | one matrix row per item
//   rsp     | rsp_valid, rsp_ready, rsp_data | one solved unknown per item
//
// A row after the first of a system takes a pop, a store read, two multiplies and a
// divider start, then DVD_W = 32 + FRAC_BITS divider steps (FRAC_BITS = 16 at Q16.16)
// and a write of the stores. Row 0 skips the read and multiplies. Each result of the
// backward sweep after the first waits on a store read, a multiply and an add, and on
// rsp_ready. Synchronous reset clears control; the stores hold no reset.
// The front keeps taking rows into a four-item queue while the back part is
// busy or its result register stalls.
module tridiagonal_thomas_solver import tts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   qstat_type q_stat;
   logic      push, pop;
   qent_type  push_data, head;

   // Tag rows with index and end-of-system mark.
   tts_front u_front (
      .clock (clock), .reset (reset),
      .req_valid (req_valid), .req_ready (req_ready), .req_data (req_data),
      .q_stat (q_stat), .push (push), .push_data (push_data)
   );

   // Decouple intake from the sweeps.
   tts_queue u_queue (
      .clock (clock), .reset (reset),
      .push (push), .push_data (push_data),
      .pop (pop), .head (head), .stat (q_stat)
   );

   // Run the forward sweep per row, the backward sweep per system.
   tts_back u_back (
      .clock (clock), .reset (reset),
      .head (head), .q_avail (q_stat.avail), .pop (pop),
      .rsp_valid (rsp_valid), .rsp_ready (rsp_ready), .rsp_data (rsp_data)
   );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the tridiagonal Thomas solver: drives matrix rows,
// predicts each solved unknown in a scoreboard class and checks every result item.
// Depends on tts_pkg and tridiagonal_thomas_solver.
`timescale 1ns / 1ps

module tb_top;
   import tts_pkg::*;

   // Scoreboard: own copy of the forward-sweep stores and the queue of
   // unknowns still to come out of the block.
   class solve_board;
      logic signed [31:0] ratio_mem [MAX_ROWS];
      logic signed [31:0] offset_mem[MAX_ROWS];
      int unsigned        rows_in;
      bit                 pivot_zero;
      rsp_type            unknowns_due[$];
      int                 errors;

      function longint sat32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // Full product, floor shift, saturate.
      function longint fx_mul(longint a, longint b);
         longint p;
         p = a * b;
         return sat32(p >>> FRAC_BITS);
      endfunction

      // Scaled quotient truncated towards zero; a zero pivot saturates by sign.
      function longint fx_div(longint num, longint den);
         if (den == 0) begin
            pivot_zero = 1'b1;
            if (num > 0) return 64'sd2147483647;
            if (num < 0) return -64'sd2147483648;
            return 0;
         end
         return sat32((num * (longint'(1) << FRAC_BITS)) / den);
      endfunction

      function void note_row(req_type r);
         longint a, b, c, d, den, num, u;
         int unsigned idx, n, row;
         rsp_type e;
         a = longint'($signed(r.sub_diag));
         b = longint'($signed(r.main_diag));
         c = longint'($signed(r.super_diag));
         d = longint'($signed(r.rhs));
         idx = rows_in % MAX_ROWS;
         if (idx == 0) begin
            den = b;
            num = d;
         end else begin
            den = sat32(b + fx_mul(a, longint'(ratio_mem[idx-1])));
            num = sat32(d - fx_mul(a, longint'(offset_mem[idx-1])));
         end
         ratio_mem[idx]  = 32'(fx_div(-c, den));
         offset_mem[idx] = 32'(fx_div(num, den));
         n = idx + 1;
         if (!r.last_row && n < MAX_ROWS) begin
            rows_in = n;
            return;
         end
         // Backward sweep: last row first, down to row 0.
         u = longint'(offset_mem[n-1]);
         for (int k = 0; k < n; k++) begin
            row = n - 1 - k;
            if (k != 0)
               u = sat32(fx_mul(longint'(ratio_mem[row]), u) + longint'(offset_mem[row]));
            e.row_index   = ROW_W'(row);
            e.solution    = 32'(u);
            e.last_of_run = (row == 0);
            e.singular    = pivot_zero;
            unknowns_due  = {unknowns_due, e};
         end
         rows_in    = 0;
         pivot_zero = 1'b0;
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (unknowns_due.size() == 0) begin
            $error("unexpected result item: row_index %0d solution %0d",
                   got.row_index, got.solution);
            errors++;
            return;
         end
         e = unknowns_due.pop_front();
         if (got.row_index !== e.row_index) begin
            $error("row_index: expected %0d, actual %0d", e.row_index, got.row_index);
            errors++;
         end
         if (got.solution !== e.solution) begin
            $error("solution: expected %0d, actual %0d", e.solution, got.solution);
            errors++;
         end
         if (got.last_of_run !== e.last_of_run) begin
            $error("last_of_run: expected %0d, actual %0d", e.last_of_run, got.last_of_run);
            errors++;
         end
         if (got.singular !== e.singular) begin
            $error("singular: expected %0d, actual %0d", e.singular, got.singular);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   solve_board sb;
   int         phase;     // 0: sender idles less, 1: receiver idles less, 2: no idling
   int         rows_sent;

   tridiagonal_thomas_solver u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Monitor both channels at the edge; note rows, check unknowns, and pick
   // the receiver's readiness for the next cycle from the current phase.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_row(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
      end
      case (phase)
         0: begin
            rsp_ready <= ($urandom_range(99) >= 48);
         end
         1: begin
            rsp_ready <= ($urandom_range(99) >= 23);
         end
         default: begin
            rsp_ready <= 1'b1;
         end
      endcase
   end

   // Present one row; hold it until accepted. Valid stays high across
   // back-to-back rows so it is never lowered and raised in one step.
   task automatic send_row(req_type r);
      int gap;
      int idle_pct;
      gap = 0;
      idle_pct = (phase == 0) ? 23 : (phase == 1) ? 48 : 0;
      if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      rows_sent++;
   endtask

   // Build a row: well-formed rows are diagonally dominant with modest
   // values; noise rows take any 32-bit value in every field.
   function automatic req_type make_row(bit noisy, bit fin);
      req_type r;
      if (noisy) begin
         r.sub_diag   = $urandom;
         r.main_diag  = $urandom;
         r.super_diag = $urandom;
         r.rhs        = $urandom;
      end else begin
         r.sub_diag   = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
         r.super_diag = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
         r.main_diag  = $signed($urandom_range(32'h0003_0000, 32'h0009_0000));
         if ($urandom_range(1)) r.main_diag = -r.main_diag;
         r.rhs        = $signed($urandom_range(0, 32'h00C8_0000)) - 32'sh0064_0000;
      end
      r.last_row = fin;
      return r;
   endfunction

   function automatic req_type row_of(int a, int b, int c, int d, bit fin);
      req_type r;
      r.sub_diag   = a;
      r.main_diag  = b;
      r.super_diag = c;
      r.rhs        = d;
      r.last_row   = fin;
      return r;
   endfunction

   // Send one system of the given length; drop last_row when the row
   // count limit is meant to close it.
   task automatic send_system(int len, int noise_pct, bit by_limit);
      bit fin;
      for (int i = 0; i < len; i++) begin
         fin = (i == len - 1) && !by_limit;
         send_row(make_row($urandom_range(99) < noise_pct, fin));
      end
   endtask

   initial begin
      sb        = new;
      phase     = 0;
      rows_sent = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero pivot with positive, negative and zero numerator.
      send_row(row_of(0, 0, 32'sh0001_0000, 32'sh0002_0000, 1'b1));
      send_row(row_of(0, 0, -32'sh0001_0000, -32'sh0002_0000, 1'b1));
      send_row(row_of(0, 0, 0, 0, 1'b1));
      // Single unknown, identity and extremes of every field.
      send_row(row_of(32'sh7FFF_FFFF, 32'sh0001_0000, 0, 32'sh7FFF_FFFF, 1'b1));
      send_row(row_of(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                      32'sh8000_0000, 1'b1));
      send_row(row_of(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                      32'sh7FFF_FFFF, 1'b1));
      send_row(row_of(0, 1, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1));
      send_row(row_of(0, -1, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1));
      // Two rows; the second's pivot becomes 2.0 after elimination.
      send_row(row_of(0, 32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000, 1'b0));
      send_row(row_of(32'sh0001_0000, 32'sh0001_0000, 0, 32'sh0003_0000, 1'b1));
      // Saturating products in the forward sweep.
      send_row(row_of(0, 1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0));
      send_row(row_of(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                      32'sh8000_0000, 1'b0));
      send_row(row_of(32'sh8000_0000, 1, 1, 32'sh7FFF_FFFF, 1'b1));
      // Three-row well-formed system.
      send_system(3, 0, 1'b0);

      // Random part. Phases shift at row counts; full-size systems begun before row
      // 400 are closed by the row count limit, later ones by last_row on row 64.
      while (rows_sent < 480) begin
         if (rows_sent >= 320) phase = 2;
         else if (rows_sent >= 160) phase = 1;
         case ($urandom_range(19))
            0:       send_system(MAX_ROWS, 5, (rows_sent < 400));
            1, 2:    send_system($urandom_range(1, 4), 100, 1'b0);
            default: send_system($urandom_range(1, 10), 10, 1'b0);
         endcase
      end
      req_valid <= 1'b0;
      // Let the monitor note the final row before waiting on the queue.
      @(posedge clock);

      // Drain, then let the pipeline settle for stray items.
      while (sb.unknowns_due.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tridiagonal_thomas_solver: match");
      end else begin
         $display("tridiagonal_thomas_solver: mismatch");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #20_000_000;
      $display("tridiagonal_thomas_solver: mismatch");
      $finish;
   end

endmodule
